### hdl/max_power_dividing_factorial_assert.svh
// Assertion macros for the max_power_dividing_factorial block.
// No dependencies; included by modules that carry assertions.
`ifndef MAX_POWER_DIVIDING_FACTORIAL_ASSERT_SVH
`define MAX_POWER_DIVIDING_FACTORIAL_ASSERT_SVH
`ifndef SYNTHESIS
`define MPDF_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define MPDF_ASSERT_NEXT(label, clk, rst_n, cond, nxt) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
        else $error("assertion failed");
`else
`define MPDF_ASSERT_IMPL(label, clk, rst_n, prop)
`define MPDF_ASSERT_NEXT(label, clk, rst_n, cond, nxt)
`endif
`endif

### hdl/mpdf_pkg.sv
// Shared types and constants for the max_power_dividing_factorial block.
// No dependencies.
package mpdf_pkg;
    localparam int NUM_WIDTH = 16;
    localparam int CNT_WIDTH = $clog2(NUM_WIDTH + 1);

    // Divider request and response.
    typedef struct packed {
        logic                 start;
        logic [NUM_WIDTH-1:0] dividend;
        logic [NUM_WIDTH-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [NUM_WIDTH-1:0] quot;
        logic [NUM_WIDTH-1:0] rem;
    } div_rsp_t;
endpackage

### hdl/mpdf_divider.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on mpdf_pkg and the assertion header.
`include "max_power_dividing_factorial_assert.svh"
module mpdf_divider
    import mpdf_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);
    logic [NUM_WIDTH-1:0] quot_reg, quot_next;
    logic [NUM_WIDTH-1:0] rem_reg, rem_next;
    logic [NUM_WIDTH-1:0] dvs_reg, dvs_next;
    logic [CNT_WIDTH-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [NUM_WIDTH:0]   trial;
    logic [NUM_WIDTH:0]   diff;

    always_comb begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {rem_reg, quot_reg[NUM_WIDTH-1]};
        diff  = trial - {1'b0, dvs_reg};
        if (req.start) begin
            quot_next = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = CNT_WIDTH'(NUM_WIDTH);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!diff[NUM_WIDTH]) begin
                rem_next  = diff[NUM_WIDTH-1:0];
                quot_next = {quot_reg[NUM_WIDTH-2:0], 1'b1};
            end else begin
                rem_next  = trial[NUM_WIDTH-1:0];
                quot_next = {quot_reg[NUM_WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_WIDTH'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg;

    `MPDF_ASSERT_NEXT(a_done_ends_busy, aclk, aresetn, done_reg, !busy_reg)
    `MPDF_ASSERT_IMPL(a_done_excl_busy, aclk, aresetn, !(done_reg && busy_reg))
    `MPDF_ASSERT_NEXT(a_start_busy, aclk, aresetn, req.start, busy_reg)
endmodule

### hdl/max_power_dividing_factorial.sv
// Top level of max_power_dividing_factorial: sequencer around one divider.
// Depends on mpdf_pkg, mpdf_divider and the assertion header.
//
//   channel | direction | ports
//   s_      | in        | s_valid s_ready s_base_value s_n_value
//   m_      | out       | m_valid m_ready m_power m_divisible m_base_invalid
//
// The time a beat takes varies with the divisions it needs, all run in turn
// on the single shared divider. Trial division of the base runs over
// candidates p with p*p <= rest, each candidate needing one division; each
// prime factor adds its divisions for the exponent and Legendre sum. Reset
// is synchronous and active low. A result waits in the output register
// while m_ready is low; no new beat is taken until it has been delivered.
`include "max_power_dividing_factorial_assert.svh"
module max_power_dividing_factorial
    import mpdf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [NUM_WIDTH-1:0] s_base_value,
    input  logic [NUM_WIDTH-1:0] s_n_value,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [NUM_WIDTH-1:0] m_power,
    output logic                 m_divisible,
    output logic                 m_base_invalid
);
    // Sequencer states.
    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_TRY      = 4'd1; // divide rest by p
    localparam logic [3:0] ST_TRY_W    = 4'd2;
    localparam logic [3:0] ST_EXP      = 4'd3; // strip factor p from rest
    localparam logic [3:0] ST_EXP_W    = 4'd4;
    localparam logic [3:0] ST_LEG      = 4'd5; // n / pw term
    localparam logic [3:0] ST_LEG_W    = 4'd6;
    localparam logic [3:0] ST_QUOT     = 4'd7; // sum / e
    localparam logic [3:0] ST_QUOT_W   = 4'd8;
    localparam logic [3:0] ST_OUT      = 4'd9;
    localparam logic [3:0] ST_PW       = 4'd10; // pw * p product check

    localparam int SUM_WIDTH = NUM_WIDTH + 1;
    localparam int PW_WIDTH  = 2 * NUM_WIDTH;

    logic [3:0]           state_reg, state_next;
    logic [NUM_WIDTH-1:0] n_reg, n_next;
    logic [NUM_WIDTH-1:0] rest_reg, rest_next;
    logic [NUM_WIDTH-1:0] p_reg, p_next;
    logic [NUM_WIDTH-1:0] e_reg, e_next;
    logic [NUM_WIDTH-1:0] pw_reg, pw_next;
    logic [SUM_WIDTH-1:0] sum_reg, sum_next;
    logic [NUM_WIDTH-1:0] best_reg, best_next;
    logic                 have_reg, have_next;
    logic                 last_reg, last_next; // Legendre for the leftover prime
    logic                 inv_reg, inv_next;
    logic [PW_WIDTH-1:0]  prod_reg, prod_next;
    logic                 mv_reg, mv_next;

    div_req_t div_req;
    div_rsp_t div_rsp;

    mpdf_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    logic [PW_WIDTH-1:0] p_sq;
    assign p_sq = PW_WIDTH'(p_reg) * PW_WIDTH'(p_reg);

    always_comb begin
        state_next = state_reg;
        n_next     = n_reg;
        rest_next  = rest_reg;
        p_next     = p_reg;
        e_next     = e_reg;
        pw_next    = pw_reg;
        sum_next   = sum_reg;
        best_next  = best_reg;
        have_next  = have_reg;
        last_next  = last_reg;
        inv_next   = inv_reg;
        prod_next  = prod_reg;
        mv_next    = mv_reg;
        div_req    = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    n_next    = s_n_value;
                    rest_next = s_base_value;
                    p_next    = NUM_WIDTH'(2);
                    have_next = 1'b0;
                    best_next = '0;
                    last_next = 1'b0;
                    inv_next  = s_base_value < NUM_WIDTH'(2);
                    state_next = (s_base_value < NUM_WIDTH'(2)) ? ST_OUT : ST_TRY;
                end
            end
            ST_TRY: begin
                // Candidate loop ends once p*p passes rest.
                if (p_sq > PW_WIDTH'(rest_reg)) begin
                    if (rest_reg > NUM_WIDTH'(1)) begin
                        p_next    = rest_reg;
                        e_next    = NUM_WIDTH'(1);
                        last_next = 1'b1;
                        pw_next   = rest_reg;
                        sum_next  = '0;
                        state_next = ST_LEG;
                    end else begin
                        state_next = ST_OUT;
                    end
                end else begin
                    div_req.start    = 1'b1;
                    div_req.dividend = rest_reg;
                    div_req.divisor  = p_reg;
                    state_next = ST_TRY_W;
                end
            end
            ST_TRY_W: begin
                if (div_rsp.done) begin
                    if (div_rsp.rem == '0) begin
                        rest_next  = div_rsp.quot;
                        e_next     = NUM_WIDTH'(1);
                        state_next = ST_EXP;
                    end else begin
                        p_next     = p_reg + 1'b1;
                        state_next = ST_TRY;
                    end
                end
            end
            ST_EXP: begin
                div_req.start    = 1'b1;
                div_req.dividend = rest_reg;
                div_req.divisor  = p_reg;
                state_next = ST_EXP_W;
            end
            ST_EXP_W: begin
                if (div_rsp.done) begin
                    if (div_rsp.rem == '0) begin
                        rest_next  = div_rsp.quot;
                        e_next     = e_reg + 1'b1;
                        state_next = ST_EXP;
                    end else begin
                        pw_next    = p_reg;
                        sum_next   = '0;
                        state_next = ST_LEG;
                    end
                end
            end
            ST_LEG: begin
                if (pw_reg > n_reg) begin
                    state_next = ST_QUOT;
                end else begin
                    div_req.start    = 1'b1;
                    div_req.dividend = n_reg;
                    div_req.divisor  = pw_reg;
                    state_next = ST_LEG_W;
                end
            end
            ST_LEG_W: begin
                if (div_rsp.done) begin
                    sum_next   = sum_reg + SUM_WIDTH'(div_rsp.quot);
                    prod_next  = PW_WIDTH'(pw_reg) * PW_WIDTH'(p_reg);
                    state_next = ST_PW;
                end
            end
            ST_PW: begin
                // Stop once the next power would exceed n.
                if (prod_reg > PW_WIDTH'(n_reg)) begin
                    state_next = ST_QUOT;
                end else begin
                    pw_next    = prod_reg[NUM_WIDTH-1:0];
                    state_next = ST_LEG;
                end
            end
            ST_QUOT: begin
                // The Legendre sum of n stays below n, so it fits the divider.
                div_req.start    = 1'b1;
                div_req.dividend = sum_reg[NUM_WIDTH-1:0];
                div_req.divisor  = e_reg;
                state_next = ST_QUOT_W;
            end
            ST_QUOT_W: begin
                if (div_rsp.done) begin
                    if (!have_reg || div_rsp.quot < best_reg) begin
                        best_next = div_rsp.quot;
                        have_next = 1'b1;
                    end
                    if (last_reg) begin
                        state_next = ST_OUT;
                    end else begin
                        p_next     = p_reg + 1'b1;
                        state_next = ST_TRY;
                    end
                end
            end
            ST_OUT: begin
                if (!mv_reg) begin
                    mv_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
        end
        n_reg    <= n_next;
        rest_reg <= rest_next;
        p_reg    <= p_next;
        e_reg    <= e_next;
        pw_reg   <= pw_next;
        sum_reg  <= sum_next;
        best_reg <= best_next;
        have_reg <= have_next;
        last_reg <= last_next;
        inv_reg  <= inv_next;
        prod_reg <= prod_next;
    end

    // Idle and no result pending: the output register is free for the new beat.
    assign s_ready        = (state_reg == ST_IDLE) && !mv_reg;
    assign m_valid        = mv_reg;
    assign m_power        = inv_reg ? '0 : best_reg;
    assign m_divisible    = !inv_reg && (best_reg != '0);
    assign m_base_invalid = inv_reg;

    `MPDF_ASSERT_IMPL(a_ready_no_pending, aclk, aresetn, !(s_ready && m_valid))
    `MPDF_ASSERT_NEXT(a_accept_busy, aclk, aresetn, s_valid && s_ready, !s_ready)
    `MPDF_ASSERT_IMPL(a_inv_zero, aclk, aresetn, !(m_valid && m_base_invalid && m_divisible))
endmodule
